// File: sv/safe_relative_path_checker_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the relative path checker
// Shared concurrent assertion forms, reset-qualified on the block clock.
// ----------------------------------------------------------------------------
`ifndef SAFE_RELATIVE_PATH_CHECKER_CORE_ASSERT_SVH
`define SAFE_RELATIVE_PATH_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication
`define SRPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srpc same-cycle check failed");

// Next-cycle implication
`define SRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srpc next-cycle check failed");

`endif

// File: sv/srpc_pkg.sv
// ----------------------------------------------------------------------------
// srpc_pkg
// Types and constants for the relative path checker.
// ----------------------------------------------------------------------------
package srpc_pkg;

    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 3;
    localparam int CODE_W    = 21;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [VERDICT_W-1:0] t_verdict;
    typedef logic [CODE_W-1:0]    t_code;

    // Verdict codes; UTF8 through COMP in priority order, highest first
    localparam t_verdict VERDICT_OK     = 3'd0;
    localparam t_verdict VERDICT_UTF8   = 3'd1;
    localparam t_verdict VERDICT_UNSAFE = 3'd2;
    localparam t_verdict VERDICT_DRIVE  = 3'd3;
    localparam t_verdict VERDICT_COMP   = 3'd4;

    // Byte values
    localparam t_byte CH_SLASH     = 8'h2F;
    localparam t_byte CH_BACKSLASH = 8'h5C;
    localparam t_byte CH_DOT       = 8'h2E;
    localparam t_byte CH_COLON     = 8'h3A;
    localparam t_byte CH_DEL       = 8'h7F;
    localparam t_byte CH_SPACE     = 8'h20;
    localparam t_byte CONT_MASK    = 8'hC0;
    localparam t_byte CONT_TAG     = 8'h80;
    localparam t_byte LEAD2_LO     = 8'hC2;
    localparam t_byte LEAD2_HI     = 8'hDF;
    localparam t_byte LEAD3_LO     = 8'hE0;
    localparam t_byte LEAD3_HI     = 8'hEF;
    localparam t_byte LEAD4_LO     = 8'hF0;
    localparam t_byte LEAD4_HI     = 8'hF4;

    // Code point limits
    localparam t_code CP_MIN3      = 21'h000800;
    localparam t_code CP_MIN4      = 21'h010000;
    localparam t_code CP_MAX       = 21'h10FFFF;
    localparam t_code CP_SURR_LO   = 21'h00D800;
    localparam t_code CP_SURR_HI   = 21'h00DFFF;

endpackage

// File: sv/srpc_if.sv
// ----------------------------------------------------------------------------
// srpc_in_if / srpc_out_if
// Valid/ready channels for path bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface srpc_in_if;
    logic              valid;
    logic              ready;
    srpc_pkg::t_byte   path_byte;
    logic              byte_present;
    logic              last;

    modport source (output valid, output path_byte, output byte_present,
                    output last, input ready);
    modport sink   (input valid, input path_byte, input byte_present,
                    input last, output ready);
endinterface

interface srpc_out_if;
    logic               valid;
    logic               ready;
    srpc_pkg::t_verdict verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// File: sv/safe_relative_path_checker_core.sv
// ----------------------------------------------------------------------------
// safe_relative_path_checker_core
// Streaming UTF-8 and relative path safety checker, one verdict per path.
// ----------------------------------------------------------------------------
//  channel | dir | fields                           | transfer
//  i_in    | in  | path_byte, byte_present, last    | valid && ready
//  o_out   | out | verdict                          | valid && ready
//
//  One item per cycle while the skid entry is free. The path state updates in
//  the cycle of the transfer; the verdict of an end item is registered for o_out.
//  A result register plus one skid entry keep input flowing while o_out
//  stalls; i_in.ready drops only while the skid entry is occupied.
//  i_rst_n is synchronous, active low; it clears path state and outputs.
// ----------------------------------------------------------------------------
`include "safe_relative_path_checker_core_assert.svh"

module safe_relative_path_checker_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srpc_in_if.sink           i_in,
    srpc_out_if.source        o_out
);

    localparam int CODE_SHIFT_HI = srpc_pkg::CODE_W - 7;

    // Path state
    logic [1:0]            r_cont_left, n_cont_left;
    logic [2:0]            r_seq_width, n_seq_width;
    srpc_pkg::t_code       r_code_accum, n_code_accum;
    logic                  r_utf8_bad, n_utf8_bad;
    logic                  r_unsafe_seen, n_unsafe_seen;
    logic                  r_first_is_letter, n_first_is_letter;
    logic [1:0]            r_byte_pos, n_byte_pos;
    logic                  r_drive_seen, n_drive_seen;
    logic [1:0]            r_comp_len, n_comp_len;
    logic                  r_comp_all_dots, n_comp_all_dots;
    logic                  r_comp_bad, n_comp_bad;

    // Output register and skid entry
    logic                  r_out_valid;
    srpc_pkg::t_verdict    r_out_verdict;
    logic                  r_skid_valid;
    srpc_pkg::t_verdict    r_skid_verdict;

    logic                  in_fire;
    logic                  out_fire;
    logic                  end_fire;
    logic                  end_stall;
    logic                  path_idle;
    srpc_pkg::t_byte       b;
    logic                  letter;
    logic                  comp_forbidden;
    srpc_pkg::t_code       cont_code;
    srpc_pkg::t_verdict    verdict;

    assign i_in.ready    = !r_skid_valid;
    assign in_fire       = i_in.valid && i_in.ready;
    assign out_fire      = r_out_valid && o_out.ready;
    assign end_fire      = in_fire && i_in.last;
    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_out_verdict;

    assign b      = i_in.path_byte;
    assign letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    assign cont_code = {r_code_accum[CODE_SHIFT_HI:0], b[5:0]};

    always_comb begin
        n_cont_left       = r_cont_left;
        n_seq_width       = r_seq_width;
        n_code_accum      = r_code_accum;
        n_utf8_bad        = r_utf8_bad;
        n_unsafe_seen     = r_unsafe_seen;
        n_first_is_letter = r_first_is_letter;
        n_byte_pos        = r_byte_pos;
        n_drive_seen      = r_drive_seen;
        n_comp_len        = r_comp_len;
        n_comp_all_dots   = r_comp_all_dots;
        n_comp_bad        = r_comp_bad;

        if (i_in.byte_present) begin
            // UTF-8 decode
            if (r_cont_left != 2'd0) begin
                if ((b & srpc_pkg::CONT_MASK) != srpc_pkg::CONT_TAG) begin
                    n_utf8_bad  = 1'b1;
                    n_cont_left = 2'd0;
                end else begin
                    n_code_accum = cont_code;
                    n_cont_left  = r_cont_left - 2'd1;
                    if (r_cont_left == 2'd1) begin
                        if ((r_seq_width == 3'd3 && cont_code < srpc_pkg::CP_MIN3) ||
                            (r_seq_width == 3'd4 && cont_code < srpc_pkg::CP_MIN4) ||
                            cont_code > srpc_pkg::CP_MAX ||
                            (cont_code >= srpc_pkg::CP_SURR_LO &&
                             cont_code <= srpc_pkg::CP_SURR_HI)) begin
                            n_utf8_bad = 1'b1;
                        end
                    end
                end
            end else if (b <= srpc_pkg::CH_DEL) begin
                n_seq_width  = 3'd1;
                n_code_accum = {13'd0, b};
            end else if (b >= srpc_pkg::LEAD2_LO && b <= srpc_pkg::LEAD2_HI) begin
                n_seq_width  = 3'd2;
                n_code_accum = {16'd0, b[4:0]};
                n_cont_left  = 2'd1;
            end else if (b >= srpc_pkg::LEAD3_LO && b <= srpc_pkg::LEAD3_HI) begin
                n_seq_width  = 3'd3;
                n_code_accum = {17'd0, b[3:0]};
                n_cont_left  = 2'd2;
            end else if (b >= srpc_pkg::LEAD4_LO && b <= srpc_pkg::LEAD4_HI) begin
                n_seq_width  = 3'd4;
                n_code_accum = {18'd0, b[2:0]};
                n_cont_left  = 2'd3;
            end else begin
                n_utf8_bad = 1'b1;
            end

            // Character class checks
            if (b < srpc_pkg::CH_SPACE || b == srpc_pkg::CH_DEL ||
                b == srpc_pkg::CH_BACKSLASH) begin
                n_unsafe_seen = 1'b1;
            end
            if (r_byte_pos == 2'd0) begin
                if (b == srpc_pkg::CH_SLASH) begin
                    n_unsafe_seen = 1'b1;
                end
                n_first_is_letter = letter;
            end else if (r_byte_pos == 2'd1) begin
                if (r_first_is_letter && b == srpc_pkg::CH_COLON) begin
                    n_drive_seen = 1'b1;
                end
            end
            if (r_byte_pos != 2'd2) begin
                n_byte_pos = r_byte_pos + 2'd1;
            end

            // Component tracking
            if (b == srpc_pkg::CH_SLASH) begin
                if (r_comp_len == 2'd0 || (r_comp_all_dots && r_comp_len != 2'd3)) begin
                    n_comp_bad = 1'b1;
                end
                n_comp_len      = 2'd0;
                n_comp_all_dots = 1'b1;
            end else begin
                if (b != srpc_pkg::CH_DOT) begin
                    n_comp_all_dots = 1'b0;
                end
                if (r_comp_len != 2'd3) begin
                    n_comp_len = r_comp_len + 2'd1;
                end
            end
        end
    end

    // Final component: empty, "." or ".."
    assign comp_forbidden = (n_comp_len == 2'd0) ||
                            (n_comp_all_dots && n_comp_len != 2'd3);

    always_comb begin
        if (n_utf8_bad || n_cont_left != 2'd0) begin
            verdict = srpc_pkg::VERDICT_UTF8;
        end else if (n_byte_pos == 2'd0 || n_unsafe_seen) begin
            verdict = srpc_pkg::VERDICT_UNSAFE;
        end else if (n_drive_seen) begin
            verdict = srpc_pkg::VERDICT_DRIVE;
        end else if (n_comp_bad || comp_forbidden) begin
            verdict = srpc_pkg::VERDICT_COMP;
        end else begin
            verdict = srpc_pkg::VERDICT_OK;
        end
    end

    // Path state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || end_fire) begin
            r_cont_left       <= 2'd0;
            r_seq_width       <= 3'd0;
            r_code_accum      <= '0;
            r_utf8_bad        <= 1'b0;
            r_unsafe_seen     <= 1'b0;
            r_first_is_letter <= 1'b0;
            r_byte_pos        <= 2'd0;
            r_drive_seen      <= 1'b0;
            r_comp_len        <= 2'd0;
            r_comp_all_dots   <= 1'b1;
            r_comp_bad        <= 1'b0;
        end else if (in_fire) begin
            r_cont_left       <= n_cont_left;
            r_seq_width       <= n_seq_width;
            r_code_accum      <= n_code_accum;
            r_utf8_bad        <= n_utf8_bad;
            r_unsafe_seen     <= n_unsafe_seen;
            r_first_is_letter <= n_first_is_letter;
            r_byte_pos        <= n_byte_pos;
            r_drive_seen      <= n_drive_seen;
            r_comp_len        <= n_comp_len;
            r_comp_all_dots   <= n_comp_all_dots;
            r_comp_bad        <= n_comp_bad;
        end
    end

    // Result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= end_fire;
            end
        end else if (end_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out_verdict <= r_skid_valid ? r_skid_verdict : verdict;
        end
        if (r_out_valid && !out_fire && end_fire) begin
            r_skid_verdict <= verdict;
        end
    end

    assign end_stall = r_out_valid && !o_out.ready && end_fire;
    assign path_idle = r_cont_left == 2'd0 && r_byte_pos == 2'd0 && r_comp_all_dots;

    `SRPC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SRPC_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n, end_stall, r_skid_valid)
    `SRPC_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, end_fire, path_idle)
    `SRPC_ASSERT_NOW(a_verdict_range, i_clk, i_rst_n, r_out_valid, r_out_verdict <= srpc_pkg::VERDICT_COMP)

endmodule
